/* hdl/rrsq_pkg.sv */
// Shared types and constants for the round robin service queue.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrsq_pkg;

    localparam int ID_W     = 16;
    localparam int TOK_W    = 8;
    localparam int STATUS_W = 2;
    localparam int QSIZE_W  = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Item kinds carried on s_tuser
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input transaction
        logic exec;   // perform the queue update and latch the result
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/rrsq_ctrl.sv */
// Sequencing controller for the round robin service queue.
// Depends on rrsq_pkg; drives the datapath through rrsq_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module rrsq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output rrsq_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign cmd.load = s_tvalid && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

/* hdl/rrsq_dpath.sv */
// Queue storage, pointers, id counter and result registers.
// Depends on rrsq_pkg; commanded by rrsq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rrsq_dpath #(
    parameter int DEPTH = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  rrsq_pkg::cmd_t                         cmd,
    input  wire logic                              in_mode,
    input  wire logic [rrsq_pkg::TOK_W-1:0]        in_tokens,
    output logic      [rrsq_pkg::STATUS_W-1:0]     out_status,
    output logic      [rrsq_pkg::ID_W-1:0]         out_id,
    output logic      [rrsq_pkg::TOK_W-1:0]        out_tokens,
    output logic      [rrsq_pkg::QSIZE_W-1:0]      out_qsize
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    logic [rrsq_pkg::ID_W-1:0]  id_mem  [DEPTH];
    logic [rrsq_pkg::TOK_W-1:0] cnt_mem [DEPTH];

    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;
    logic [OCC_W-1:0]              occ_reg, occ_next;
    logic [rrsq_pkg::ID_W-1:0]     next_id_reg, next_id_next;
    logic                          mode_reg;
    logic [rrsq_pkg::TOK_W-1:0]    tok_reg;
    logic [rrsq_pkg::ID_W-1:0]     rd_id_reg;
    logic [rrsq_pkg::TOK_W-1:0]    rd_cnt_reg;

    logic                          wr_en;
    logic [rrsq_pkg::ID_W-1:0]     wr_id;
    logic [rrsq_pkg::TOK_W-1:0]    wr_cnt;
    logic [rrsq_pkg::STATUS_W-1:0] status_next;
    logic [rrsq_pkg::ID_W-1:0]     id_next;
    logic [rrsq_pkg::TOK_W-1:0]    left_next;
    logic [OCC_W+2:0]              occ_wide;

    logic [rrsq_pkg::STATUS_W-1:0] status_reg;
    logic [rrsq_pkg::ID_W-1:0]     id_reg;
    logic [rrsq_pkg::TOK_W-1:0]    left_reg;
    logic [rrsq_pkg::QSIZE_W-1:0]  qsize_reg;

    // Head read is registered; head never moves between accept and exec,
    // and the last write landed before the head read that exec uses.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[tail_reg]  <= wr_id;
            cnt_mem[tail_reg] <= wr_cnt;
        end
        rd_id_reg  <= id_mem[head_reg];
        rd_cnt_reg <= cnt_mem[head_reg];
    end

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        next_id_next = next_id_reg;
        wr_en        = 1'b0;
        wr_id        = rd_id_reg;
        wr_cnt       = tok_reg;
        status_next  = rrsq_pkg::ST_OK;
        id_next      = '0;
        left_next    = '0;
        if (mode_reg == rrsq_pkg::MODE_ARRIVE) begin
            // id counter advances even when the arrival is dropped
            next_id_next = next_id_reg + 1'b1;
            id_next      = next_id_next;
            if (occ_reg == FULL_OCC) begin
                status_next = rrsq_pkg::ST_FULL;
            end else begin
                wr_en     = 1'b1;
                wr_id     = next_id_next;
                wr_cnt    = tok_reg;
                tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                occ_next  = occ_reg + 1'b1;
            end
        end else begin
            if (occ_reg == '0) begin
                status_next = rrsq_pkg::ST_EMPTY;
            end else begin
                id_next   = rd_id_reg;
                head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                if (rd_cnt_reg > 8'd1) begin
                    // requeue at the tail; occupancy unchanged
                    left_next = rd_cnt_reg - 1'b1;
                    wr_en     = 1'b1;
                    wr_id     = rd_id_reg;
                    wr_cnt    = left_next;
                    tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                end else begin
                    occ_next = occ_reg - 1'b1;
                end
            end
        end
        if (!cmd.exec) begin
            wr_en = 1'b0;
        end
        occ_wide = {3'b000, occ_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            next_id_reg <= '0;
        end else if (cmd.exec) begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            next_id_reg <= next_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            tok_reg  <= in_tokens;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            id_reg     <= id_next;
            left_reg   <= left_next;
            qsize_reg  <= occ_wide[rrsq_pkg::QSIZE_W-1:0];
        end
    end

    assign out_status = status_reg;
    assign out_id     = id_reg;
    assign out_tokens = left_reg;
    assign out_qsize  = qsize_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= FULL_OCC)
        else $error("occupancy exceeds depth");

    a_empty_serve: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (mode_reg == rrsq_pkg::MODE_SERVE) && (occ_reg == '0)
        |=> (status_reg == rrsq_pkg::ST_EMPTY) && (id_reg == '0) && $stable(occ_reg))
        else $error("serve on empty queue mishandled");

    a_id_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (mode_reg == rrsq_pkg::MODE_ARRIVE)
        |=> next_id_reg == $past(next_id_reg) + 1'b1)
        else $error("id counter did not advance on arrival");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(occ_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("queue state changed outside exec");

endmodule

`default_nettype wire

/* hdl/round_robin_service_queue_core.sv */
// Top level of the round robin service queue: stream ports around the
// controller (rrsq_ctrl) and the datapath (rrsq_dpath). Depends on rrsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A circular queue of up to DEPTH customers, served round robin. Each input
// transaction is an arrival (s_tuser = 0, s_tdata = requested tokens) or a
// serve (s_tuser = 1, token field ignored), and yields exactly one result
// transaction with a status on m_tuser (ok, full, empty) plus the id, the
// tokens still owed and the occupancy after the step on m_tdata. Ids come
// from a 16-bit counter that starts at 1 after reset and advances on every
// arrival, dropped or not. One item is handled at a time: a transaction is
// accepted with the head read out of the entry memory, then updated, before
// its result is presented, and the next item is accepted in the cycle after
// the result is taken, so a new item is never accepted while a result is
// pending. No clearing pass follows reset.
module round_robin_service_queue_core #(
    parameter int DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] token_count
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] customer_id, [23:16] tokens_left,
                                        // [26:24] queue_size, [31:27] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    rrsq_pkg::cmd_t                        cmd;
    logic [rrsq_pkg::ID_W-1:0]             res_id;
    logic [rrsq_pkg::TOK_W-1:0]            res_tokens;
    logic [rrsq_pkg::QSIZE_W-1:0]          res_qsize;

    rrsq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rrsq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_mode    (s_tuser),
        .in_tokens  (s_tdata),
        .out_status (m_tuser),
        .out_id     (res_id),
        .out_tokens (res_tokens),
        .out_qsize  (res_qsize)
    );

    assign m_tdata = {5'b00000, res_qsize, res_tokens, res_id};

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for round_robin_service_queue_core: directed table, then random
// arrive/serve traffic with bursty sender and patterned receiver stalls.
// Depends on rrsq_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int STATUS_W       = rrsq_pkg::STATUS_W;
    localparam int ID_W           = rrsq_pkg::ID_W;
    localparam int TOK_W          = rrsq_pkg::TOK_W;
    localparam int QSIZE_W        = rrsq_pkg::QSIZE_W;
    localparam int QUEUE_DEPTH    = 4;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLDOFF_CYCLES = 120;
    localparam int TAIL_CYCLES    = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     cust_id;
        logic [TOK_W-1:0]    tokens_left;
        logic [QSIZE_W-1:0]  qsize;
    } outcome_t;

    typedef struct {
        logic             mode;
        logic [TOK_W-1:0] tokens;
        bit               typed;   // row carries its own expected outcome
        outcome_t         want;
    } stim_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_pattern_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = rrsq_pkg::MODE_ARRIVE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // queue shadow
    logic [ID_W-1:0]  shadow_ids    [QUEUE_DEPTH];
    logic [TOK_W-1:0] shadow_counts [QUEUE_DEPTH];
    int unsigned      shadow_head = 0;
    int unsigned      shadow_tail = 0;
    int unsigned      shadow_fill = 0;
    logic [ID_W-1:0]  id_counter  = '0;

    outcome_t pending_outcomes[$];
    int       mismatches  = 0;
    int       burst_left  = 0;
    int       holdoff_reqs = 0;
    int       holdoff_seen = 0;
    int       hold_cnt     = 0;
    rx_pattern_t rx_pattern = RX_ALWAYS;
    int       pattern_cnt  = 0;
    int       rx_tick      = 0;

    round_robin_service_queue_core #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic void append_customer(logic [ID_W-1:0] id, logic [TOK_W-1:0] count);
        shadow_ids[shadow_tail]    = id;
        shadow_counts[shadow_tail] = count;
        shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
        shadow_fill++;
    endfunction

    // Advances the shadow queue by one transaction and returns its outcome.
    function automatic outcome_t queue_step(logic mode, logic [TOK_W-1:0] tokens);
        outcome_t         r;
        logic [TOK_W-1:0] cnt;
        r = '{rrsq_pkg::ST_OK, '0, '0, '0};
        if (mode == rrsq_pkg::MODE_ARRIVE) begin
            id_counter = id_counter + 1'b1;
            r.cust_id = id_counter;
            if (shadow_fill >= QUEUE_DEPTH)
                r.status = rrsq_pkg::ST_FULL;
            else
                append_customer(id_counter, tokens);
        end else if (shadow_fill == 0) begin
            r.status = rrsq_pkg::ST_EMPTY;
        end else begin
            r.cust_id = shadow_ids[shadow_head];
            cnt = shadow_counts[shadow_head];
            shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
            shadow_fill--;
            if (cnt > 1) begin
                r.tokens_left = cnt - 1'b1;
                append_customer(r.cust_id, r.tokens_left);
            end
        end
        r.qsize = QSIZE_W'(shadow_fill);
        return r;
    endfunction

    // Holds the item until accepted, then records what the block must answer.
    task automatic offer_item(input logic mode, input logic [TOK_W-1:0] tokens,
                              input bit typed, input outcome_t typed_want);
        outcome_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= tokens;
        do @(posedge aclk); while (!s_tready);
        predicted = queue_step(mode, tokens);
        pending_outcomes.push_back(typed ? typed_want : predicted);
    endtask

    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= TOK_W'($urandom);
                s_tuser  <= 1'($urandom);
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
    endtask

    // Mostly short stays so customers cycle through; full range only when the arrival drops.
    function automatic logic [TOK_W-1:0] pick_tokens();
        if (shadow_fill >= QUEUE_DEPTH)
            return TOK_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            return TOK_W'($urandom_range(5, 24));
        return TOK_W'($urandom_range(0, 4));
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Receiver: a randomly chosen pattern drives m_tready; a requested hold-off overrides it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_reqs != holdoff_seen) begin
            holdoff_seen <= holdoff_reqs;
            hold_cnt     <= HOLDOFF_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (pattern_cnt == 0) begin
                rx_pattern  <= rx_pattern_t'($urandom_range(0, 3));
                pattern_cnt <= $urandom_range(16, 96);
            end else begin
                pattern_cnt <= pattern_cnt - 1;
            end
            case (rx_pattern)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_RARELY:   m_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_tready <= (rx_tick % 3 == 0);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result transaction, expected none, got %h/%h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("customer_id", 32'(want.cust_id), 32'(m_tdata[15:0]));
                check_field("tokens_left", 32'(want.tokens_left), 32'(m_tdata[23:16]));
                check_field("queue_size", 32'(want.qsize), 32'(m_tdata[26:24]));
                check_field("pad bits", 32'd0, 32'(m_tdata[31:27]));
            end
        end
    end

    initial begin : stimulus
        stim_row_t        directed_rows[$];
        stim_row_t        row;
        logic             mode;
        int               arrive_pct;
        int               n;

        // Serve the empty queue, fill to capacity, drop two arrivals, then rotate entries with 0, 1, 2 and 255 tokens.
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b1,
                                  '{rrsq_pkg::ST_EMPTY, 16'd0, 8'd0,   3'd0}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd0,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd1, 8'd0,   3'd1}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd255, 1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd2, 8'd0,   3'd2}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd1,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd3, 8'd0,   3'd3}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd2,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd4, 8'd0,   3'd4}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'hAA,  1'b1,
                                  '{rrsq_pkg::ST_FULL,  16'd5, 8'd0,   3'd4}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'h55,  1'b1,
                                  '{rrsq_pkg::ST_FULL,  16'd6, 8'd0,   3'd4}});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd255, 1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd1, 8'd0,   3'd3}});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd2, 8'd254, 3'd3}});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd3, 8'd0,   3'd2}});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b1,
                                  '{rrsq_pkg::ST_OK,    16'd4, 8'd1,   3'd2}});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd6,   1'b0, '0});
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd0,   1'b0, '0});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b0, '0});  // serve when full
        directed_rows.push_back('{rrsq_pkg::MODE_ARRIVE, 8'd9,   1'b0, '0});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b0, '0});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b0, '0});
        directed_rows.push_back('{rrsq_pkg::MODE_SERVE,  8'd0,   1'b0, '0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            pace_sender();
            offer_item(row.mode, row.tokens, row.typed, row.want);
        end

        // the long-stay customer must work its way out before random traffic
        while (shadow_fill != 0) begin
            pace_sender();
            offer_item(rrsq_pkg::MODE_SERVE, TOK_W'($urandom), 1'b0, '0);
        end

        arrive_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: arrive_pct = 25;
                    1: arrive_pct = 50;
                    default: arrive_pct = 75;
                endcase
            end
            if (n == 300)
                wait_results_drained();
            if (n == 700)
                holdoff_reqs++;  // sender keeps offering while the receiver is held off
            mode = ($urandom_range(0, 99) < arrive_pct) ? rrsq_pkg::MODE_ARRIVE
                                                        : rrsq_pkg::MODE_SERVE;
            pace_sender();
            offer_item(mode, pick_tokens(), 1'b0, '0);
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
